/* src/itb_pkg.sv */
// Package for the interval timer bank: field widths, operation codes,
// controller states and the control struct between the controller and the result buffer.
// No dependencies.
`default_nettype none

package itb_pkg;

    // Field widths of a command transaction and of a result transaction.
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 3;
    localparam int PER_W   = 24;
    localparam int DELTA_W = 16;

    // Accumulator is Q24.8 in frames; a period is compared as period << FRAC_W.
    localparam int FRAC_W = 8;
    localparam int ACC_W  = PER_W + FRAC_W;

    // Default bank size and the number of fire results one tick may report.
    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_OUT        = 8;
    localparam int CNT_W          = $clog2(MAX_OUT + 1);
    localparam int DIDX_W         = $clog2(MAX_OUT);

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_ADD_ONE  = 3'd1,
        OP_ADD_REP  = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_STOP     = 3'd4,
        OP_STOP_ALL = 3'd5,
        OP_CLEAR    = 3'd6,
        OP_RESTART  = 3'd7
    } itb_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_EMIT
    } itb_state_t;

    // Controller to result buffer.
    typedef struct packed {
        logic              clr;        // empty the fire list
        logic              push;       // append a fired slot
        logic [SLOT_W-1:0] push_slot;
        logic              start;      // begin sending the results of this command
        logic              status;     // status of a single non-fire result
    } itb_buf_ctl_t;

endpackage

`default_nettype wire

/* src/itb_cmd_if.sv */
// Command channel of the interval timer bank: valid/ready and the command fields.
// Depends on itb_pkg.
`default_nettype none

interface itb_cmd_if import itb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [SLOT_W-1:0]  slot;
    logic [PER_W-1:0]   period_frames;
    logic [DELTA_W-1:0] delta;

    modport source (output valid, operation, slot, period_frames, delta, input ready);
    modport sink   (input valid, operation, slot, period_frames, delta, output ready);
endinterface

`default_nettype wire

/* src/itb_evt_if.sv */
// Result channel of the interval timer bank: valid/ready and the result fields.
// Depends on itb_pkg.
`default_nettype none

interface itb_evt_if import itb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic              fired;
    logic [SLOT_W-1:0] fired_slot;
    logic              last;

    modport source (output valid, status, fired, fired_slot, last, input ready);
    modport sink   (input valid, status, fired, fired_slot, last, output ready);
endinterface

`default_nettype wire

/* src/itb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module itb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/itb_result_buf.sv */
// Result buffer: collects the slots that fire during a tick and sends one result
// transaction per fire (or one plain result) through an output register.
// Depends on itb_pkg and itb_evt_if.
`default_nettype none

module itb_result_buf import itb_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire itb_buf_ctl_t ctl,
    output logic              busy,
    itb_evt_if.source         evt
);

    logic [SLOT_W-1:0] list_reg [MAX_OUT];
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIDX_W-1:0] didx_reg;
    logic              emit_reg;
    logic              status_reg;
    logic              out_vld_reg;
    logic              out_status_reg;
    logic              out_fired_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_last_reg;

    logic out_free;
    logic load;
    logic is_last;
    logic room;

    assign room     = cnt_reg < CNT_W'(MAX_OUT);
    assign out_free = !out_vld_reg || evt.ready;
    assign load     = emit_reg && out_free;
    assign is_last  = (cnt_reg == '0) || ((CNT_W'(didx_reg) + CNT_W'(1)) == cnt_reg);
    assign busy     = emit_reg;

    // Fire list storage; fires beyond the list size are dropped.
    always_ff @(posedge clk)
    begin
        if (ctl.push && room)
        begin
            list_reg[cnt_reg[DIDX_W-1:0]] <= ctl.push_slot;
        end
    end

    // List count and emission control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            didx_reg    <= '0;
            emit_reg    <= 1'b0;
            status_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                cnt_reg <= '0;
            end
            else if (ctl.push && room)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (ctl.start)
            begin
                emit_reg   <= 1'b1;
                didx_reg   <= '0;
                status_reg <= ctl.status;
            end
            else if (load)
            begin
                didx_reg <= didx_reg + DIDX_W'(1);
                if (is_last)
                begin
                    emit_reg <= 1'b0;
                end
            end

            if (load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_last_reg <= is_last;
            if (cnt_reg == '0)
            begin
                out_status_reg <= status_reg;
                out_fired_reg  <= 1'b0;
                out_slot_reg   <= '0;
            end
            else
            begin
                out_status_reg <= 1'b0;
                out_fired_reg  <= 1'b1;
                out_slot_reg   <= list_reg[didx_reg];
            end
        end
    end

    assign evt.valid      = out_vld_reg;
    assign evt.status     = out_status_reg;
    assign evt.fired      = out_fired_reg;
    assign evt.fired_slot = out_slot_reg;
    assign evt.last       = out_last_reg;

    // The list is never appended to while it is being sent.
    a_no_push_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !emit_reg)
        else $error("fire pushed while results are being sent");

    // A result without a fire is always the only, hence last, one.
    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_fired_reg) |-> out_last_reg)
        else $error("plain result not marked last");

    // A stalled result transaction stays valid and unchanged.
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !evt.ready) |=> (out_vld_reg
            && $stable({out_status_reg, out_fired_reg, out_slot_reg, out_last_reg})))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

/* src/interval_timer_bank.sv */
// Interval timer bank: one-shot and repeating timers with period and accumulator in RAM.
// A tick walks the slots in ST_WALK (one RAM read per slot) and finishes the last slot's
// accumulator read-modify-write in ST_FLUSH, then sends one result per listed fire. Any other
// command is applied when accepted; the bank is idle again once its result is loaded for sending.
// Reset (rst_n, asynchronous, active low) frees every slot; RAM contents are not cleared
// because an entry is only read after an add has written it.
`default_nettype none

module interval_timer_bank import itb_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    itb_cmd_if.sink   cmd,
    itb_evt_if.source evt
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

    itb_state_t state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  s2_vld_reg;
    logic [IDX_W-1:0]      s2_idx_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic [NUM_TIMERS-1:0] occ_reg, occ_next;
    logic [NUM_TIMERS-1:0] pend_reg, pend_next;
    logic [NUM_TIMERS-1:0] run_reg, run_next;
    logic [NUM_TIMERS-1:0] rep_reg, rep_next;

    itb_buf_ctl_t ctl;
    logic         buf_busy;

    logic             per_we;
    logic [IDX_W-1:0] per_waddr;
    logic [PER_W-1:0] per_rd;
    logic             acc_we;
    logic [IDX_W-1:0] acc_waddr;
    logic [ACC_W-1:0] acc_wdata;
    logic [ACC_W-1:0] acc_rd;

    logic [IDX_W-1:0] si;
    logic             slot_ok;
    logic             occ_sel;
    logic [ACC_W:0]   sum_wide;
    logic [ACC_W-1:0] sum_sat;
    logic             fire_hit;
    logic             accept;

    // Period and accumulator storage.
    itb_ram #(.WIDTH(PER_W), .DEPTH(NUM_TIMERS)) u_per_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (per_waddr),
        .wdata (cmd.period_frames),
        .raddr (idx_reg),
        .rdata (per_rd)
    );

    itb_ram #(.WIDTH(ACC_W), .DEPTH(NUM_TIMERS)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (idx_reg),
        .rdata (acc_rd)
    );

    itb_result_buf u_result_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .busy  (buf_busy),
        .evt   (evt)
    );

    // Slot decode for per-slot commands.
    assign si      = IDX_W'(cmd.slot);
    assign slot_ok = 7'(cmd.slot) < 7'(NUM_TIMERS);
    assign occ_sel = slot_ok && occ_reg[si];

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // Saturating accumulator update and expiry compare for the slot in the second stage.
    assign sum_wide = {1'b0, acc_rd} + (ACC_W + 1)'(delta_reg);
    assign sum_sat  = sum_wide[ACC_W] ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
    assign fire_hit = sum_sat > {per_rd, {FRAC_W{1'b0}}};

    // Sequencer, command decode and the slot read-modify-write stage.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        occ_next   = occ_reg;
        pend_next  = pend_reg;
        run_next   = run_reg;
        rep_next   = rep_reg;
        ctl        = '0;
        per_we     = 1'b0;
        per_waddr  = si;
        acc_we     = 1'b0;
        acc_waddr  = si;
        acc_wdata  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.clr = 1'b1;
                    if (itb_op_t'(cmd.operation) == OP_TICK)
                    begin
                        idx_next   = '0;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_EMIT;
                        case (itb_op_t'(cmd.operation))
                            OP_ADD_ONE, OP_ADD_REP:
                            begin
                                ctl.status = !slot_ok || occ_sel;
                                if (slot_ok && !occ_sel)
                                begin
                                    occ_next[si]  = 1'b1;
                                    pend_next[si] = 1'b0;
                                    run_next[si]  = 1'b1;
                                    rep_next[si]  = (itb_op_t'(cmd.operation) == OP_ADD_REP);
                                    per_we        = 1'b1;
                                    acc_we        = 1'b1;
                                end
                            end
                            OP_REMOVE:
                            begin
                                ctl.status = !occ_sel;
                                if (occ_sel)
                                begin
                                    run_next[si]  = 1'b0;
                                    pend_next[si] = 1'b1;
                                end
                            end
                            OP_STOP:
                            begin
                                ctl.status = !occ_sel;
                                if (occ_sel)
                                begin
                                    run_next[si] = 1'b0;
                                end
                            end
                            OP_STOP_ALL:
                            begin
                                run_next = '0;
                            end
                            OP_CLEAR:
                            begin
                                occ_next  = '0;
                                pend_next = '0;
                                run_next  = '0;
                                rep_next  = '0;
                            end
                            OP_RESTART:
                            begin
                                ctl.status = !occ_sel;
                                if (occ_sel)
                                begin
                                    run_next[si] = 1'b1;
                                    acc_we       = 1'b1;
                                end
                            end
                            default:
                            begin
                                ctl.status = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_WALK:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                ctl.start  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!buf_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Second stage of the walk: RAM data for s2_idx_reg is now available.
        if (s2_vld_reg && occ_reg[s2_idx_reg])
        begin
            if (pend_reg[s2_idx_reg])
            begin
                occ_next[s2_idx_reg]  = 1'b0;
                pend_next[s2_idx_reg] = 1'b0;
                run_next[s2_idx_reg]  = 1'b0;
                rep_next[s2_idx_reg]  = 1'b0;
            end
            else if (run_reg[s2_idx_reg])
            begin
                acc_we    = 1'b1;
                acc_waddr = s2_idx_reg;
                acc_wdata = fire_hit ? '0 : sum_sat;
                if (fire_hit)
                begin
                    ctl.push      = 1'b1;
                    ctl.push_slot = SLOT_W'(s2_idx_reg);
                    if (!rep_reg[s2_idx_reg])
                    begin
                        pend_next[s2_idx_reg] = 1'b1;
                    end
                end
            end
        end
    end

    // Control and slot flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            s2_vld_reg <= 1'b0;
            s2_idx_reg <= '0;
            occ_reg    <= '0;
            pend_reg   <= '0;
            run_reg    <= '0;
            rep_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            s2_vld_reg <= (state_reg == ST_WALK);
            s2_idx_reg <= idx_reg;
            occ_reg    <= occ_next;
            pend_reg   <= pend_next;
            run_reg    <= run_next;
            rep_reg    <= rep_next;
        end
    end

    // Tick delta captured with the transaction.
    always_ff @(posedge clk)
    begin
        if (accept && itb_op_t'(cmd.operation) == OP_TICK)
        begin
            delta_reg <= cmd.delta;
        end
    end

    // The second stage only runs in the walk and flush states of a tick.
    a_s2_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (state_reg == ST_WALK || state_reg == ST_FLUSH))
        else $error("slot stage active outside a tick walk");

    // Pending removal and running are only ever set on occupied slots.
    a_flags_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_reg | run_reg) & ~occ_reg) == '0)
        else $error("flag set on a free slot");

    // The walk index never leaves the bank.
    a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg <= IDX_LAST))
        else $error("walk index beyond the last slot");

endmodule

`default_nettype wire

/* dv/interval_timer_bank_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for interval_timer_bank: directed and random command transactions,
// with a scoreboard class that predicts the result transactions of every accepted command.
// Depends on itb_pkg, itb_cmd_if, itb_evt_if and interval_timer_bank.

module interval_timer_bank_test;

    import itb_pkg::*;

    localparam int NUM_SLOTS    = NUM_TIMERS_DEF;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = NUM_SLOTS + 3 + MAX_OUT + 16;
    localparam int PHASE_ITEMS  = 117;

    // One result transaction as seen on the result channel.
    typedef struct packed {
        logic              status;
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic              last;
    } bank_event_t;

    // Timer bank model and the queue of result transactions it still expects.
    class timer_bank_scoreboard;
        bit               occupied [NUM_SLOTS];
        bit               free_pending [NUM_SLOTS];
        bit               running [NUM_SLOTS];
        bit               repeating [NUM_SLOTS];
        logic [PER_W-1:0] period [NUM_SLOTS];
        logic [ACC_W-1:0] elapsed [NUM_SLOTS];
        bank_event_t      expected_q [$];
        int               error_count;
        int               command_count;
        int               event_count;
        int               fire_count;
        int               busiest_tick;

        function void release_slot(int i);
            occupied[i]     = 1'b0;
            free_pending[i] = 1'b0;
            running[i]      = 1'b0;
            repeating[i]    = 1'b0;
        endfunction

        // Apply one accepted command to the model and queue the results it causes.
        function void note_command(itb_op_t op, logic [SLOT_W-1:0] s,
                                   logic [PER_W-1:0] per, logic [DELTA_W-1:0] d);
            logic [SLOT_W-1:0] hits [$];
            logic [ACC_W:0]    sum;
            bank_event_t       ev;
            bit                in_range;
            bit                fail;
            int                i;
            in_range = int'(s) < NUM_SLOTS;
            fail = 1'b0;
            command_count++;
            if (op == OP_TICK) begin
                // Walk the slots in ascending order: free, accumulate, fire.
                for (i = 0; i < NUM_SLOTS; i++) begin
                    if (!occupied[i])
                        continue;
                    if (free_pending[i]) begin
                        release_slot(i);
                        continue;
                    end
                    if (!running[i])
                        continue;
                    sum = {1'b0, elapsed[i]} + (ACC_W + 1)'(d);
                    elapsed[i] = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
                    if (elapsed[i] > {period[i], {FRAC_W{1'b0}}}) begin
                        elapsed[i] = '0;
                        if (!repeating[i])
                            free_pending[i] = 1'b1;
                        if (hits.size() < MAX_OUT)
                            hits.push_back(SLOT_W'(i));
                    end
                end
                fire_count += hits.size();
                if (hits.size() > busiest_tick)
                    busiest_tick = hits.size();
                if (hits.size() == 0) begin
                    ev = '{status: 1'b0, fired: 1'b0, fired_slot: '0, last: 1'b1};
                    expected_q.push_back(ev);
                end
                for (i = 0; i < hits.size(); i++) begin
                    ev = '{status: 1'b0, fired: 1'b1, fired_slot: hits[i],
                           last: (i == hits.size() - 1)};
                    expected_q.push_back(ev);
                end
                return;
            end
            case (op)
                OP_ADD_ONE, OP_ADD_REP:
                begin
                    if (!in_range || occupied[s])
                        fail = 1'b1;
                    else
                    begin
                        occupied[s]     = 1'b1;
                        free_pending[s] = 1'b0;
                        running[s]      = 1'b1;
                        repeating[s]    = (op == OP_ADD_REP);
                        period[s]       = per;
                        elapsed[s]      = '0;
                    end
                end
                OP_REMOVE:
                begin
                    if (!in_range || !occupied[s])
                        fail = 1'b1;
                    else
                    begin
                        running[s]      = 1'b0;
                        free_pending[s] = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    if (!in_range || !occupied[s])
                        fail = 1'b1;
                    else
                        running[s] = 1'b0;
                end
                OP_STOP_ALL:
                begin
                    for (i = 0; i < NUM_SLOTS; i++)
                        running[i] = 1'b0;
                end
                OP_CLEAR:
                begin
                    for (i = 0; i < NUM_SLOTS; i++)
                        release_slot(i);
                end
                default:
                begin
                    // Restart keeps a pending removal in place.
                    if (!in_range || !occupied[s])
                        fail = 1'b1;
                    else
                    begin
                        running[s] = 1'b1;
                        elapsed[s] = '0;
                    end
                end
            endcase
            ev = '{status: fail, fired: 1'b0, fired_slot: '0, last: 1'b1};
            expected_q.push_back(ev);
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        function void check_result(bank_event_t got);
            bank_event_t want;
            event_count++;
            if (expected_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction status=%0d fired=%0d slot=%0d last=%0d",
                         $time, got.status, got.fired, got.fired_slot, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.fired !== want.fired
                || got.fired_slot !== want.fired_slot || got.last !== want.last) begin
                error_count++;
                $display("%0t: result mismatch: expected status=%0d fired=%0d slot=%0d last=%0d",
                         $time, want.status, want.fired, want.fired_slot, want.last);
                $display("%0t:                  actual status=%0d fired=%0d slot=%0d last=%0d",
                         $time, got.status, got.fired, got.fired_slot, got.last);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sink_ready = 1'b0;
    int                   src_idle_pct = 0;
    int                   sink_idle_pct = 0;
    int                   cycle_count = 0;
    timer_bank_scoreboard sb;

    itb_cmd_if cmd_bus ();
    itb_evt_if evt_bus ();

    assign evt_bus.ready = sink_ready;

    interval_timer_bank u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus.sink),
        .evt   (evt_bus.source)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
            $display("interval_timer_bank regression: fail");
            $finish;
        end
    end

    // Result side: check each accepted transaction and stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_bus.valid && evt_bus.ready)
                sb.check_result({evt_bus.status, evt_bus.fired, evt_bus.fired_slot,
                                 evt_bus.last});
            sink_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one command transaction, with a random gap first, and hold it until accepted.
    task automatic send_command(input itb_op_t op, input logic [SLOT_W-1:0] s,
                                input logic [PER_W-1:0] per, input logic [DELTA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.operation     <= op;
        cmd_bus.slot          <= s;
        cmd_bus.period_frames <= per;
        cmd_bus.delta         <= d;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        sb.note_command(op, s, per, d);
    endtask

    // Random commands, weighted toward adds and ticks with short periods so that timers fire.
    task automatic run_random_phase(input int src_pct, input int sink_pct, input int count);
        itb_op_t          op;
        logic [PER_W-1:0] per;
        logic [DELTA_W-1:0] d;
        int               pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 36)
                op = OP_TICK;
            else if (pick < 50)
                op = OP_ADD_ONE;
            else if (pick < 64)
                op = OP_ADD_REP;
            else if (pick < 73)
                op = OP_REMOVE;
            else if (pick < 81)
                op = OP_STOP;
            else if (pick < 93)
                op = OP_RESTART;
            else if (pick < 97)
                op = OP_STOP_ALL;
            else
                op = OP_CLEAR;
            per = ($urandom_range(99) < 85) ? PER_W'($urandom_range(6)) : PER_W'($urandom());
            pick = $urandom_range(99);
            if (pick < 10)
                d = '0;
            else if (pick < 80)
                d = DELTA_W'($urandom_range(16'h0300, 16'h0020));
            else
                d = DELTA_W'($urandom());
            send_command(op, SLOT_W'($urandom_range(NUM_SLOTS - 1)), per, d);
        end
    endtask

    initial
    begin
        int i;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.operation     <= OP_TICK;
        cmd_bus.slot          <= '0;
        cmd_bus.period_frames <= '0;
        cmd_bus.delta         <= '0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty bank, failures on empty slots, add on an occupied slot.
        src_idle_pct  = 28;
        sink_idle_pct = 59;
        send_command(OP_TICK, 3'd0, '0, 16'hFFFF);
        send_command(OP_REMOVE, 3'd3, '0, '0);
        send_command(OP_STOP, 3'd4, '0, '0);
        send_command(OP_RESTART, 3'd5, '0, '0);
        send_command(OP_ADD_ONE, 3'd0, '0, '0);
        send_command(OP_ADD_REP, 3'd0, 24'd5, '0);
        send_command(OP_ADD_REP, 3'd7, 24'hFFFFFF, '0);
        send_command(OP_ADD_REP, 3'd1, 24'd1, '0);
        send_command(OP_ADD_ONE, 3'd2, 24'd2, '0);
        // A zero delta fires nothing, not even a zero period.
        send_command(OP_TICK, 3'd0, '0, 16'h0000);
        send_command(OP_TICK, 3'd0, '0, 16'h0101);
        // The fired one-shot is pending removal: add fails, restart succeeds.
        send_command(OP_ADD_ONE, 3'd0, 24'd3, '0);
        send_command(OP_RESTART, 3'd0, '0, '0);
        // Slot 1 lands exactly on its period and must not fire.
        send_command(OP_TICK, 3'd0, '0, 16'h0100);
        send_command(OP_STOP, 3'd7, '0, '0);
        send_command(OP_RESTART, 3'd7, '0, '0);
        send_command(OP_REMOVE, 3'd1, '0, '0);
        send_command(OP_STOP_ALL, 3'd6, '0, '0);
        send_command(OP_TICK, 3'd0, '0, 16'h0001);
        send_command(OP_CLEAR, 3'd0, '0, '0);
        // Every slot fires on one tick: the most results a tick can give.
        for (i = 0; i < NUM_SLOTS; i++)
            send_command(OP_ADD_REP, SLOT_W'(i), '0, '0);
        send_command(OP_TICK, 3'd0, '0, 16'hFFFF);
        send_command(OP_CLEAR, 3'd0, '0, '0);

        // Random traffic under three idling patterns.
        run_random_phase(28, 59, PHASE_ITEMS);
        run_random_phase(59, 28, PHASE_ITEMS);
        run_random_phase(0, 0, PHASE_ITEMS);
        cmd_bus.valid <= 1'b0;

        // Drain, then give the block time to show any stray transaction.
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d result transactions, %0d of them timer expiries.",
                 sb.command_count, sb.event_count, sb.fire_count);
        $display("Busiest tick reported %0d expiries; %0d errors found.",
                 sb.busiest_tick, sb.error_count);
        if (sb.error_count == 0)
            $display("interval_timer_bank regression: pass");
        else
            $display("interval_timer_bank regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/itb_pkg.sv
src/itb_cmd_if.sv
src/itb_evt_if.sv
src/itb_ram.sv
src/itb_result_buf.sv
src/interval_timer_bank.sv
dv/interval_timer_bank_test.sv
